[rtl/tccw_pkg.sv]
// Shared types, constants and codes for the text console character writer.
package tccw_pkg;

  localparam int TEXT_COLUMNS = 80;
  localparam int TEXT_ROWS    = 25;
  localparam int TAB_WIDTH    = 4;

  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int ADDR_W     = 11;
  localparam int WORD_W     = 16;
  localparam int CHAR_W     = 8;
  localparam int COORD_W    = 16;
  localparam int COLOR_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic REQ_PRINT = 1'b0;
  localparam logic REQ_SET   = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic [CFG_IDX_W-1:0] CFG_BG     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR = 2'd2;

  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;
  localparam logic [COLOR_W-1:0] FG_RESET = 4'h7;

  typedef enum logic [2:0] {
    OP_PUT = 3'd0,
    OP_NL  = 3'd1,
    OP_CR  = 3'd2,
    OP_TAB = 3'd3,
    OP_BS  = 3'd4,
    OP_SET = 3'd5
  } op_t;

  typedef struct packed {
    logic                      req_type;
    logic [CHAR_W-1:0]         char_code;
    logic signed [COORD_W-1:0] set_row;
    logic signed [COORD_W-1:0] set_col;
  } in_req_t;

  typedef struct packed {
    logic              cell_write;
    logic [ADDR_W-1:0] cell_addr;
    logic [WORD_W-1:0] cell_word;
    logic              cursor_write;
    logic [ADDR_W-1:0] cursor_pos;
    logic [ROW_W-1:0]  new_row;
    logic [COL_W-1:0]  new_col;
  } out_res_t;

  // Classified request as held in the queue
  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } cmd_t;

  typedef struct packed {
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] fg;
    logic               cursor_on;
  } cfg_t;

endpackage

[rtl/tccw_front.sv]
// Front end: decodes a request into an operation and clamps set coordinates.
module tccw_front (
  input  logic              in_valid,
  input  tccw_pkg::in_req_t in_req,
  input  logic              q_full,
  output logic              in_ready,
  output logic              push,
  output tccw_pkg::cmd_t    cmd
);
  import tccw_pkg::*;

  logic [ROW_W-1:0] row_clamp;
  logic [COL_W-1:0] col_clamp;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    if (in_req.set_row[COORD_W-1]) begin
      row_clamp = '0;
    end else if ($unsigned(in_req.set_row) >= COORD_W'(TEXT_ROWS)) begin
      row_clamp = ROW_W'(TEXT_ROWS - 1);
    end else begin
      row_clamp = in_req.set_row[ROW_W-1:0];
    end

    if (in_req.set_col[COORD_W-1]) begin
      col_clamp = '0;
    end else if ($unsigned(in_req.set_col) >= COORD_W'(TEXT_COLUMNS)) begin
      col_clamp = COL_W'(TEXT_COLUMNS - 1);
    end else begin
      col_clamp = in_req.set_col[COL_W-1:0];
    end
  end

  always_comb begin
    cmd.char_code = in_req.char_code;
    cmd.row       = row_clamp;
    cmd.col       = col_clamp;
    if (in_req.req_type == REQ_SET) begin
      cmd.op = OP_SET;
    end else begin
      unique case (in_req.char_code)
        CHAR_NL:  cmd.op = OP_NL;
        CHAR_CR:  cmd.op = OP_CR;
        CHAR_TAB: cmd.op = OP_TAB;
        CHAR_BS:  cmd.op = OP_BS;
        default:  cmd.op = OP_PUT;
      endcase
    end
  end

endmodule

[rtl/tccw_queue.sv]
// Two-entry request queue between front end and back end.
module tccw_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tccw_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           head_valid,
  output tccw_pkg::cmd_t head_cmd,
  input  logic           pop
);
  import tccw_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/tccw_back.sv]
// Back end: cursor state, cell word build and the registered result.
module tccw_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tccw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                cmd_valid,
  input  tccw_pkg::cmd_t                      cmd,
  output logic                                cmd_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tccw_pkg::out_res_t                  out_res
);
  import tccw_pkg::*;

  localparam int COLX_W = COL_W + 1;
  localparam int ROWX_W = ROW_W + 1;

  cfg_t             cfg_r, cfg_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_res_t         out_res_r, out_res_nxt;

  logic [COLX_W-1:0] col_x;
  logic [ROWX_W-1:0] row_x;
  logic [COL_W-1:0]  cell_col;
  logic              wr;
  logic [CHAR_W-1:0] wr_char;
  logic [ADDR_W-1:0] cell_addr;
  logic [ADDR_W-1:0] cursor_pos;
  logic              load;

  assign load      = cmd_valid && (!out_valid_r || out_ready);
  assign cmd_pop   = load;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // cursor update
  always_comb begin
    col_x    = {1'b0, col_r};
    row_x    = {1'b0, row_r};
    cell_col = col_r;
    wr       = 1'b0;
    wr_char  = cmd.char_code;
    unique case (cmd.op)
      OP_SET: begin
        row_x = {1'b0, cmd.row};
        col_x = {1'b0, cmd.col};
      end
      OP_NL: begin
        row_x = row_x + 1'b1;
        col_x = '0;
      end
      OP_CR: col_x = '0;
      OP_TAB: col_x = col_x + COLX_W'(TAB_WIDTH) - COLX_W'(col_x % TAB_WIDTH);
      OP_BS: begin
        if (col_r != '0) begin
          col_x    = col_x - 1'b1;
          cell_col = col_r - 1'b1;
          wr       = 1'b1;
          wr_char  = CHAR_SPACE;
        end
      end
      OP_PUT: begin
        col_x = col_x + 1'b1;
        wr    = 1'b1;
      end
      default: ;
    endcase
    if (col_x >= COLX_W'(TEXT_COLUMNS)) begin
      col_x = '0;
      row_x = row_x + 1'b1;
    end
    if (row_x >= ROWX_W'(TEXT_ROWS)) begin
      row_x = '0;
    end
  end

  assign cell_addr  = ADDR_W'(row_r) * ADDR_W'(TEXT_COLUMNS) + ADDR_W'(cell_col);
  assign cursor_pos = ADDR_W'(row_x) * ADDR_W'(TEXT_COLUMNS) + ADDR_W'(col_x);

  always_comb begin
    cfg_nxt       = cfg_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_BG:     cfg_nxt.bg        = cfg_wdata;
        CFG_FG:     cfg_nxt.fg        = cfg_wdata;
        CFG_CURSOR: cfg_nxt.cursor_on = cfg_wdata[0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (load) begin
      row_nxt                  = row_x[ROW_W-1:0];
      col_nxt                  = col_x[COL_W-1:0];
      out_valid_nxt            = 1'b1;
      out_res_nxt.cell_write   = wr;
      out_res_nxt.cell_addr    = wr ? cell_addr : '0;
      out_res_nxt.cell_word    = wr ? {cfg_r.bg, cfg_r.fg, wr_char} : '0;
      out_res_nxt.cursor_write = cfg_r.cursor_on;
      out_res_nxt.cursor_pos   = cfg_r.cursor_on ? cursor_pos : '0;
      out_res_nxt.new_row      = row_x[ROW_W-1:0];
      out_res_nxt.new_col      = col_x[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{bg: BG_RESET, fg: FG_RESET, cursor_on: 1'b0};
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

endmodule

[rtl/text_console_char_writer.sv]
// An accepted request goes into the queue, then from its head into the out_* register.
// Throughput: one request per cycle; while a result waits for out_ready the two-entry
//   queue takes two more requests, then in_ready drops until the back end drains one.
// Reset (rst_n low, synchronous): cursor at row 0 column 0, background 0,
//   foreground 7, cursor reporting off, queue and output register empty.
module text_console_char_writer (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tccw_pkg::in_req_t               in_req,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output tccw_pkg::out_res_t              out_res,
  // register writes, only while idle
  input  logic                            cfg_we,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tccw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tccw_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  // Front: decode the character into an operation and clamp set coordinates.
  // This needs no cursor state, so it runs straight off the request port.
  tccw_front u_front (
    .in_valid (in_valid),
    .in_req   (in_req),
    .q_full   (q_full),
    .in_ready (in_ready),
    .push     (push),
    .cmd      (push_cmd)
  );

  // Queue decouples request acceptance from result backpressure.
  tccw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  // Back: owns the cursor; one queued request is applied per cycle when the
  // output register is free or being drained.
  tccw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .cmd_pop   (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

endmodule

[rtl/tccw_checker.sv]
// Port-level checks for the text console character writer, bound to the top level.
module tccw_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input tccw_pkg::out_res_t   out_res
);
  import tccw_pkg::*;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("stalled result changed");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.new_row < ROW_W'(TEXT_ROWS)) &&
                  (out_res.new_col < COL_W'(TEXT_COLUMNS)))
    else $error("cursor off screen");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.cell_write |-> out_res.cell_addr == '0 && out_res.cell_word == '0)
    else $error("cell fields set without a write");

  a_cursor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.cursor_write |-> out_res.cursor_pos == '0)
    else $error("cursor position set while cursor off");

endmodule

bind text_console_char_writer tccw_checker u_tccw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_res   (out_res)
);
